// ===== rtl/nearest_active_entry_search_core_assert.svh =====
// assertion macros used by the port-level checker file
`ifndef NEAREST_ACTIVE_ENTRY_SEARCH_CORE_ASSERT_SVH
`define NEAREST_ACTIVE_ENTRY_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk and held off during reset
`define NAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and held off during reset
`define NAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nae_pkg.sv =====
// shared types, widths and helpers for the nearest entry search
package nae_pkg;

  localparam int IDX_W   = 6;
  localparam int POS_W   = 24;
  localparam int WHOLE_W = 16;
  localparam int DIFF_W  = WHOLE_W + 1;
  localparam int DIST_W  = 34;
  localparam int MAX_TBL = 1 << IDX_W;

  // only slots reachable by the index field can ever be live
  function automatic int tbl_depth(int n);
    return (n < MAX_TBL) ? n : MAX_TBL;
  endfunction

  typedef struct packed {
    logic             start;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             out_load;
  } nae_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } nae_sts_t;

endpackage

// ===== rtl/nae_ram.sv =====
// generic single write port, single read port ram with registered read
module nae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nae_ctrl.sv =====
// controller for the nearest entry search: accept, scan, drain, result
module nae_ctrl #(
  parameter int NUM_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_stall,
  input  nae_pkg::nae_sts_t sts,
  output nae_pkg::nae_cmd_t cmd
);
  import nae_pkg::*;

  localparam int TBL = tbl_depth(NUM_ENTRIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TBL - 1);
  localparam logic OP_WRITE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_RES   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_operation == OP_WRITE) begin
            cmd.wr_en = 1'b1;
            state_nxt = ST_RES;
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cnt_r;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== rtl/nae_dp.sv =====
// datapath: entry table, distance pipeline, best tracker and result register
module nae_dp #(
  parameter int NUM_ENTRIES   = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nae_pkg::nae_cmd_t                  cmd,
  output nae_pkg::nae_sts_t                  sts,
  input  logic [nae_pkg::IDX_W-1:0]          in_entry_index,
  input  logic signed [nae_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [nae_pkg::POS_W-1:0]   in_pos_y,
  input  logic                               in_set_active,
  input  logic                               in_set_ghost,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [nae_pkg::IDX_W-1:0]          out_nearest_index,
  output logic [nae_pkg::DIST_W-1:0]         out_nearest_distance
);
  import nae_pkg::*;

  localparam int TBL = tbl_depth(NUM_ENTRIES);
  localparam int AW  = (TBL > 1) ? $clog2(TBL) : 1;
  localparam logic [IDX_W:0] TBL_LIM = (IDX_W + 1)'(TBL);

  // whole-unit conversion: floor shift, then wrap to 16 bits
  logic signed [POS_W-1:0] sx, sy;
  logic [WHOLE_W-1:0]      wx, wy;
  assign sx = in_pos_x >>> FRACTION_BITS;
  assign sy = in_pos_y >>> FRACTION_BITS;
  assign wx = sx[WHOLE_W-1:0];
  assign wy = sy[WHOLE_W-1:0];

  logic idx_ok, we;
  assign idx_ok = ({1'b0, in_entry_index} < TBL_LIM);
  assign we     = cmd.wr_en && idx_ok;

  logic [AW-1:0]          waddr, raddr;
  logic [2*WHOLE_W-1:0]   rdata;
  assign waddr = in_entry_index[AW-1:0];
  assign raddr = cmd.rd_addr[AW-1:0];

  nae_ram #(
    .WIDTH (2 * WHOLE_W),
    .DEPTH (TBL)
  ) u_tbl (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({wx, wy}),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // live means active and not a ghost
  logic live_r [TBL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL; i++) begin
        live_r[i] <= 1'b0;
      end
    end else if (we) begin
      live_r[waddr] <= in_set_active && !in_set_ghost;
    end
  end

  logic [WHOLE_W-1:0] qx_r, qy_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r <= wx;
      qy_r <= wy;
    end
  end

  // stage 1: ram data out, absolute differences
  logic             v1_r, live1_r;
  logic [IDX_W-1:0] idx1_r;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        ax, ay;
  logic [WHOLE_W-1:0]       ex, ey;

  assign ex = rdata[2*WHOLE_W-1:WHOLE_W];
  assign ey = rdata[WHOLE_W-1:0];
  assign dx = $signed({ex[WHOLE_W-1], ex}) - $signed({qx_r[WHOLE_W-1], qx_r});
  assign dy = $signed({ey[WHOLE_W-1], ey}) - $signed({qy_r[WHOLE_W-1], qy_r});
  assign ax = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
  assign ay = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;

  // stage 2: squares
  logic              v2_r;
  logic [IDX_W-1:0]  idx2_r;
  logic [DIFF_W-1:0] ax2_r, ay2_r;

  // stage 3: sum and compare
  logic              v3_r;
  logic [IDX_W-1:0]  idx3_r;
  logic [DIST_W-1:0] sqx3_r, sqy3_r;
  logic [DIST_W-1:0] sqx, sqy, dist_sum;
  logic              upd;

  assign sqx      = {{(DIST_W-DIFF_W){1'b0}}, ax2_r} * {{(DIST_W-DIFF_W){1'b0}}, ax2_r};
  assign sqy      = {{(DIST_W-DIFF_W){1'b0}}, ay2_r} * {{(DIST_W-DIFF_W){1'b0}}, ay2_r};
  assign dist_sum = sqx3_r + sqy3_r;

  logic              have_r;
  logic [IDX_W-1:0]  bidx_r;
  logic [DIST_W-1:0] best_r;

  assign upd = v3_r && (!have_r || (dist_sum < best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r && live1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    live1_r <= live_r[raddr];
    idx1_r  <= cmd.rd_addr;
    ax2_r   <= ax;
    ay2_r   <= ay;
    idx2_r  <= idx1_r;
    sqx3_r  <= sqx;
    sqy3_r  <= sqy;
    idx3_r  <= idx2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      bidx_r <= '0;
      best_r <= '0;
    end else if (cmd.start) begin
      have_r <= 1'b0;
      bidx_r <= '0;
      best_r <= '0;
    end else if (upd) begin
      have_r <= 1'b1;
      bidx_r <= idx3_r;
      best_r <= dist_sum;
    end
  end

  // result register parts the scan from the consumer
  logic              out_valid_r, out_found_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r <= have_r;
      out_idx_r   <= bidx_r;
      out_dist_r  <= best_r;
    end
  end

  assign sts.pipe_busy = v1_r || v2_r || v3_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_nearest_index    = out_idx_r;
  assign out_nearest_distance = out_dist_r;

endmodule

// ===== rtl/nearest_active_entry_search_core.sv =====
// Nearest active entry search core. A write item (operation 0) stores one
// table slot, and its result, all zero, goes to the output register once
// that register is free. A query item (operation 1) walks the table one
// entry per cycle through the single read port of the table RAM, feeding a
// three-stage distance pipeline; the scan covers min(NUM_ENTRIES, 64) slots,
// and the next item is taken only once the pipeline has drained and the
// result has been loaded. Results wait in an output register, so a new
// item can be taken while the last result is still stalled, but its own
// result waits until that register is free. Positions are truncated to whole
// units by a floor shift of FRACTION_BITS; the distance is exact in 34 bits
// and ties go to the lowest index. Slots at or above NUM_ENTRIES are never
// written.
module nearest_active_entry_search_core #(
  parameter int NUM_ENTRIES   = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [nae_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [nae_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [nae_pkg::POS_W-1:0] in_pos_y,
  input  logic                             in_set_active,
  input  logic                             in_set_ghost,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_found,
  output logic [nae_pkg::IDX_W-1:0]        out_nearest_index,
  output logic [nae_pkg::DIST_W-1:0]       out_nearest_distance
);
  import nae_pkg::*;

  nae_cmd_t cmd;
  nae_sts_t sts;

  nae_ctrl #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  nae_dp #(
    .NUM_ENTRIES   (NUM_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_entry_index       (in_entry_index),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_set_active        (in_set_active),
    .in_set_ghost         (in_set_ghost),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_found            (out_found),
    .out_nearest_index    (out_nearest_index),
    .out_nearest_distance (out_nearest_distance)
  );

endmodule

// ===== rtl/nae_chk.sv =====
// port-level checker for the nearest entry search core, with its bind
`include "nearest_active_entry_search_core_assert.svh"

module nae_chk #(
  parameter int NUM_ENTRIES = 64
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_operation,
  input logic [nae_pkg::IDX_W-1:0]        in_entry_index,
  input logic signed [nae_pkg::POS_W-1:0] in_pos_x,
  input logic signed [nae_pkg::POS_W-1:0] in_pos_y,
  input logic                             in_set_active,
  input logic                             in_set_ghost,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_found,
  input logic [nae_pkg::IDX_W-1:0]        out_nearest_index,
  input logic [nae_pkg::DIST_W-1:0]       out_nearest_distance
);
  import nae_pkg::*;

  localparam logic [IDX_W:0] TBL_LIM = (IDX_W + 1)'(tbl_depth(NUM_ENTRIES));

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a stalled result holds
  `NAE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_found) && $stable(out_nearest_index)
      && $stable(out_nearest_distance), "stalled result changed")

  // no item is taken back to back: each one keeps the block busy
  `NAE_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall,
    "item taken while the previous one was still in work")

  // a miss or a write reports zeros
  `NAE_ASSERT_NOW(a_miss_zero, out_valid && !out_found,
    out_nearest_index == '0 && out_nearest_distance == '0,
    "result without a hit is not all zero")

  // a hit names a slot inside the table
  `NAE_ASSERT_NOW(a_hit_in_table, out_valid && out_found,
    {1'b0, out_nearest_index} < TBL_LIM, "hit index outside the table")

endmodule

bind nearest_active_entry_search_core nae_chk #(
  .NUM_ENTRIES (NUM_ENTRIES)
) u_nae_chk (.*);
